/* rtl/kncu_pkg.sv */
// Package for the k-means nearest-centroid update unit.
// Holds sequencer states, operation codes and fixed field widths; no dependencies.
package kncu_pkg;

    localparam int CLUSTERS   = 16;
    localparam int CID_BITS   = 4;
    localparam int COORD_BITS = 16;
    localparam int SUM_BITS   = 28;
    localparam int CNT_BITS   = 13;
    localparam int SQD_BITS   = 34;
    localparam int SQ_BITS    = 33;
    localparam int KCFG_BITS  = 5;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_CLASSIFY = 2'd1;
    localparam logic [1:0] OP_UPDATE   = 2'd2;

    localparam logic [2:0] ADDR_CLUSTER_COUNT = 3'd0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIST,
        ST_DRAIN,
        ST_ACC,
        ST_POUT,
        ST_UINIT,
        ST_UDIV,
        ST_UFIN,
        ST_UEMIT,
        ST_UDONE
    } state_t;

endpackage

/* rtl/kmeans_nearest_centroid_update_unit.sv */
// 3D k-means step: centroid load, nearest-centroid classify with accumulation, mean update.
// Classify sweeps the active centroids, one axis square per cycle through a shared multiplier;
// update divides each non-empty cluster's axis sums by its count in a shared 28-step restoring
// divider, three axes, while an empty cluster keeps its centroid.
// One item at a time. After reset a clearing pass empties the assignment memory before the
// first item is taken; the control and cluster registers reset at once.
module kmeans_nearest_centroid_update_unit
    import kncu_pkg::*;
#(
    parameter int MAX_POINTS = 4096  // 1..4096, depth of the assignment memory
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // slot[11:0], coord_x[27:12], coord_y[43:28], coord_z[59:44]
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // cluster_id[3:0], squared_distance[37:4], mean_x[53:38],
                                   // mean_y[69:54], mean_z[85:70], converged[86]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PT_AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    state_t state_reg, state_next;

    logic [KCFG_BITS-1:0] ccount_reg;
    logic [KCFG_BITS-1:0] k_act;
    logic [CID_BITS-1:0]  k_last;

    logic signed [COORD_BITS-1:0] cen_x_reg [CLUSTERS];
    logic signed [COORD_BITS-1:0] cen_y_reg [CLUSTERS];
    logic signed [COORD_BITS-1:0] cen_z_reg [CLUSTERS];
    logic [SUM_BITS-1:0] sum_x_reg [CLUSTERS];
    logic [SUM_BITS-1:0] sum_y_reg [CLUSTERS];
    logic [SUM_BITS-1:0] sum_z_reg [CLUSTERS];
    logic [CNT_BITS-1:0] cnt_reg   [CLUSTERS];
    logic                change_reg;

    // point latch
    logic [11:0] slot_reg;
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg, pt_z_reg;

    logic [CID_BITS-1:0] cl_reg;
    logic [1:0]          ax_reg;

    // distance pipeline
    logic [SQ_BITS-1:0]  sq_reg;
    logic                sq_vld_reg;
    logic [1:0]          sq_ax_reg;
    logic [CID_BITS-1:0] sq_cl_reg;
    logic [SQD_BITS-1:0] acc_reg;
    logic [SQD_BITS-1:0] best_d_reg;
    logic [CID_BITS-1:0] best_reg;

    // divider
    logic [SUM_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0] den_reg;
    logic                neg_reg;
    logic [4:0]          dcnt_reg;
    logic signed [COORD_BITS-1:0] mean_reg [3];
    logic                conv_reg;

    // assignment memory: valid bit and cluster number
    logic [CID_BITS:0]   pa_mem [MAX_POINTS];
    logic [CID_BITS:0]   pa_rd_reg;
    logic [PT_AW:0]      clr_reg;
    logic                pa_we;
    logic [PT_AW-1:0]    pa_waddr;
    logic [CID_BITS:0]   pa_wdata;

    // output register
    logic                m_valid_reg;
    logic [CID_BITS-1:0] o_cid_reg;
    logic [SQD_BITS-1:0] o_sqd_reg;
    logic signed [COORD_BITS-1:0] o_mx_reg, o_my_reg, o_mz_reg;
    logic                o_conv_reg;
    logic                o_last_reg;

    logic                in_acc;
    logic                out_free;
    logic                slot_ok;
    logic [1:0]          op_in;
    logic [11:0]         slot_in;

    logic signed [COORD_BITS-1:0] cen_sel;
    logic signed [COORD_BITS-1:0] pt_sel;
    logic signed [COORD_BITS:0]   diff;
    logic signed [2*COORD_BITS+1:0] prod;
    logic [SQD_BITS-1:0]          dist_sum;

    logic [SUM_BITS-1:0]  sum_sel;
    logic [SUM_BITS-1:0]  sum_mag;
    logic [CNT_BITS:0]    div_tr;
    logic                 div_ge;
    logic signed [SUM_BITS:0] quo_s;
    logic signed [COORD_BITS-1:0] quo_sat;

    logic                 ax_wrap;
    logic                 cl_end;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = {{(32-KCFG_BITS){1'b0}}, ccount_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccount_reg <= KCFG_BITS'(1);
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_CLUSTER_COUNT)
        begin
            ccount_reg <= pwdata[KCFG_BITS-1:0];
        end
    end

    always_comb
    begin
        if (ccount_reg == '0)
            k_act = KCFG_BITS'(1);
        else if (ccount_reg > KCFG_BITS'(CLUSTERS))
            k_act = KCFG_BITS'(CLUSTERS);
        else
            k_act = ccount_reg;
    end
    assign k_last = CID_BITS'(k_act - KCFG_BITS'(1));

    // ---------------- handshake and fields ----------------
    assign op_in    = s_tuser;
    assign slot_in  = s_tdata[11:0];
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign slot_ok  = {20'd0, slot_reg} < MAX_POINTS;
    assign ax_wrap  = (ax_reg == 2'd2);
    assign cl_end   = (cl_reg == k_last);

    // ---------------- shared distance unit ----------------
    always_comb
    begin
        case (ax_reg)
            2'd0:    begin cen_sel = cen_x_reg[cl_reg]; pt_sel = pt_x_reg; end
            2'd1:    begin cen_sel = cen_y_reg[cl_reg]; pt_sel = pt_y_reg; end
            default: begin cen_sel = cen_z_reg[cl_reg]; pt_sel = pt_z_reg; end
        endcase
    end
    assign diff     = {pt_sel[COORD_BITS-1], pt_sel} - {cen_sel[COORD_BITS-1], cen_sel};
    assign prod     = diff * diff;
    assign dist_sum = acc_reg + {1'b0, sq_reg};

    // ---------------- shared divider ----------------
    always_comb
    begin
        case (ax_reg)
            2'd0:    sum_sel = sum_x_reg[cl_reg];
            2'd1:    sum_sel = sum_y_reg[cl_reg];
            default: sum_sel = sum_z_reg[cl_reg];
        endcase
    end
    assign sum_mag = sum_sel[SUM_BITS-1] ? (~sum_sel + SUM_BITS'(1)) : sum_sel;
    assign div_tr  = {rem_reg, quo_reg[SUM_BITS-1]};
    assign div_ge  = div_tr >= {1'b0, den_reg};
    assign quo_s   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_comb
    begin
        if (quo_s > $signed((SUM_BITS+1)'(32767)))
            quo_sat = 16'sh7fff;
        else if (quo_s < -$signed((SUM_BITS+1)'(32768)))
            quo_sat = 16'sh8000;
        else
            quo_sat = quo_s[COORD_BITS-1:0];
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == (PT_AW+1)'(MAX_POINTS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc)
                begin
                    if (op_in == OP_CLASSIFY)
                        state_next = ST_DIST;
                    else if (op_in == OP_UPDATE)
                        state_next = ST_UINIT;
                end
            ST_DIST:
                if (ax_wrap && cl_end)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_ACC;
            ST_ACC:
                state_next = ST_POUT;
            ST_POUT:
                if (out_free)
                    state_next = ST_IDLE;
            ST_UINIT:
                if (cnt_reg[cl_reg] == '0)
                    state_next = ST_UEMIT;
                else
                    state_next = ST_UDIV;
            ST_UDIV:
                if (dcnt_reg == 5'(SUM_BITS - 1))
                    state_next = ST_UFIN;
            ST_UFIN:
                state_next = ax_wrap ? ST_UEMIT : ST_UINIT;
            ST_UEMIT:
                if (out_free)
                    state_next = cl_end ? ST_UDONE : ST_UINIT;
            ST_UDONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_tready = 1'b0;
        pa_we    = 1'b0;
        pa_waddr = slot_reg[PT_AW-1:0];
        pa_wdata = {1'b1, best_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                pa_we    = 1'b1;
                pa_waddr = clr_reg[PT_AW-1:0];
                pa_wdata = '0;
            end
            ST_IDLE:
                s_tready = 1'b1;
            ST_ACC:
                pa_we = slot_ok;
            default:
                s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (state_reg == ST_CLEAR)
            clr_reg <= clr_reg + (PT_AW+1)'(1);
    end

    // ---------------- assignment memory ----------------
    always_ff @(posedge clk)
    begin
        if (pa_we)
            pa_mem[pa_waddr] <= pa_wdata;
        pa_rd_reg <= pa_mem[slot_reg[PT_AW-1:0]];
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            slot_reg <= slot_in;
            pt_x_reg <= s_tdata[27:12];
            pt_y_reg <= s_tdata[43:28];
            pt_z_reg <= s_tdata[59:44];
        end
        sq_reg    <= prod[SQ_BITS-1:0];
        sq_ax_reg <= ax_reg;
        sq_cl_reg <= cl_reg;
        if (sq_vld_reg)
        begin
            if (sq_ax_reg == 2'd0)
                acc_reg <= {1'b0, sq_reg};
            else
                acc_reg <= dist_sum;
            if (sq_ax_reg == 2'd2 && (sq_cl_reg == '0 || dist_sum < best_d_reg))
            begin
                best_d_reg <= dist_sum;
                best_reg   <= sq_cl_reg;
            end
        end
        if (state_reg == ST_IDLE && in_acc && op_in == OP_UPDATE)
            conv_reg <= !change_reg;
        case (state_reg)
            ST_UINIT:
            begin
                quo_reg  <= sum_mag;
                rem_reg  <= '0;
                den_reg  <= cnt_reg[cl_reg];
                neg_reg  <= sum_sel[SUM_BITS-1];
                dcnt_reg <= '0;
            end
            ST_UDIV:
            begin
                rem_reg  <= div_ge ? CNT_BITS'(div_tr - {1'b0, den_reg}) : div_tr[CNT_BITS-1:0];
                quo_reg  <= {quo_reg[SUM_BITS-2:0], div_ge};
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            ST_UFIN:
                mean_reg[ax_reg] <= quo_sat;
            default:
                dcnt_reg <= dcnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            cl_reg     <= '0;
            ax_reg     <= '0;
        end
        else
        begin
            sq_vld_reg <= (state_reg == ST_DIST);
            if (state_reg == ST_IDLE)
            begin
                cl_reg <= '0;
                ax_reg <= '0;
            end
            else if (state_reg == ST_DIST || state_reg == ST_UFIN)
            begin
                ax_reg <= ax_wrap ? 2'd0 : ax_reg + 2'd1;
                if (ax_wrap && state_reg == ST_DIST)
                    cl_reg <= cl_reg + CID_BITS'(1);
            end
            else if (state_reg == ST_UEMIT && out_free)
            begin
                ax_reg <= '0;
                cl_reg <= cl_reg + CID_BITS'(1);
            end
        end
    end

    // cluster state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLUSTERS; i++)
            begin
                cen_x_reg[i] <= '0;
                cen_y_reg[i] <= '0;
                cen_z_reg[i] <= '0;
                sum_x_reg[i] <= '0;
                sum_y_reg[i] <= '0;
                sum_z_reg[i] <= '0;
                cnt_reg[i]   <= '0;
            end
            change_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (in_acc && op_in == OP_LOAD && slot_in < 12'(CLUSTERS))
                    begin
                        cen_x_reg[slot_in[CID_BITS-1:0]] <= s_tdata[27:12];
                        cen_y_reg[slot_in[CID_BITS-1:0]] <= s_tdata[43:28];
                        cen_z_reg[slot_in[CID_BITS-1:0]] <= s_tdata[59:44];
                    end
                ST_ACC:
                begin
                    sum_x_reg[best_reg] <= sum_x_reg[best_reg]
                                           + SUM_BITS'(pt_x_reg);
                    sum_y_reg[best_reg] <= sum_y_reg[best_reg]
                                           + SUM_BITS'(pt_y_reg);
                    sum_z_reg[best_reg] <= sum_z_reg[best_reg]
                                           + SUM_BITS'(pt_z_reg);
                    cnt_reg[best_reg]   <= cnt_reg[best_reg] + CNT_BITS'(1);
                    if (!slot_ok || pa_rd_reg != {1'b1, best_reg})
                        change_reg <= 1'b1;
                end
                ST_UEMIT:
                    if (out_free && cnt_reg[cl_reg] != '0)
                    begin
                        cen_x_reg[cl_reg] <= mean_reg[0];
                        cen_y_reg[cl_reg] <= mean_reg[1];
                        cen_z_reg[cl_reg] <= mean_reg[2];
                    end
                ST_UDONE:
                begin
                    for (int i = 0; i < CLUSTERS; i++)
                    begin
                        sum_x_reg[i] <= '0;
                        sum_y_reg[i] <= '0;
                        sum_z_reg[i] <= '0;
                        cnt_reg[i]   <= '0;
                    end
                    change_reg <= 1'b0;
                end
                default:
                    change_reg <= change_reg;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if ((state_reg == ST_POUT || state_reg == ST_UEMIT) && out_free)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POUT && out_free)
        begin
            o_cid_reg  <= best_reg;
            o_sqd_reg  <= best_d_reg;
            o_mx_reg   <= '0;
            o_my_reg   <= '0;
            o_mz_reg   <= '0;
            o_conv_reg <= 1'b0;
            o_last_reg <= 1'b0;
        end
        else if (state_reg == ST_UEMIT && out_free)
        begin
            o_cid_reg  <= cl_reg;
            o_sqd_reg  <= '0;
            if (cnt_reg[cl_reg] != '0)
            begin
                o_mx_reg <= mean_reg[0];
                o_my_reg <= mean_reg[1];
                o_mz_reg <= mean_reg[2];
            end
            else
            begin
                o_mx_reg <= cen_x_reg[cl_reg];
                o_my_reg <= cen_y_reg[cl_reg];
                o_mz_reg <= cen_z_reg[cl_reg];
            end
            o_conv_reg <= conv_reg;
            o_last_reg <= cl_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {1'b0, o_conv_reg, o_mz_reg, o_my_reg, o_mx_reg, o_sqd_reg, o_cid_reg};

`ifndef SYNTHESIS
    // the divider only runs on a non-empty cluster
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UDIV) |-> (den_reg != '0))
        else $error("divider running with zero count");

    // distance sweep stays within the active clusters
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIST) |-> ({1'b0, cl_reg} < k_act))
        else $error("distance sweep past active clusters");

    // no input item taken while a result is being formed
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POUT || state_reg == ST_UEMIT) |-> !s_tready)
        else $error("input accepted during result emission");

    // a new result is only loaded into a free output register
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> $stable(o_cid_reg) && m_valid_reg)
        else $error("output register overwritten while stalled");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for kmeans_nearest_centroid_update_unit: centroid loads, point
// classification and mean updates, checked against an in-bench predictor.
// Depends on kncu_pkg and the unit's RTL only.
module tb_top;
    import kncu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = 4096;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [3:0]         cid;
        logic [33:0]        sqd;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic               conv;
        logic               last;
    } centroid_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // slot[11:0], coord_x[27:12], coord_y[43:28], coord_z[59:44]
    logic [1:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // cluster_id[3:0], squared_distance[37:4], mean_x[53:38],
                            // mean_y[69:54], mean_z[85:70], converged[86]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kmeans_nearest_centroid_update_unit u_top (.*);

    // predictor state
    logic signed [15:0] centroid[CLUSTERS][3];
    logic [27:0]        sum_x[CLUSTERS];
    logic [27:0]        sum_y[CLUSTERS];
    logic [27:0]        sum_z[CLUSTERS];
    logic [12:0]        members[CLUSTERS];
    logic [4:0]         prior[MAX_PTS];
    logic               moved;
    logic [4:0]         k_reg;

    centroid_result_t expected_q[$];
    int errors;
    int items_sent;
    int src_idle_pct;
    int snk_stall_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic signed [15:0] mean_of(logic [27:0] acc, logic [12:0] n);
        longint s;
        longint q;
        s = longint'(signed'(acc));
        q = s / longint'(n);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    // works out the results of one accepted item and queues them
    function automatic void predict_kmeans(logic [1:0] op, logic [11:0] slot,
                                           logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z);
        int k;
        int best;
        longint best_d;
        longint d;
        longint dx;
        longint dy;
        longint dz;
        centroid_result_t r;
        k = (k_reg == 0) ? 1 : ((k_reg > CLUSTERS) ? CLUSTERS : int'(k_reg));
        if (op == OP_LOAD)
        begin
            if (slot < CLUSTERS)
            begin
                centroid[slot][0] = x;
                centroid[slot][1] = y;
                centroid[slot][2] = z;
            end
        end
        else if (op == OP_CLASSIFY)
        begin
            best = 0;
            best_d = 0;
            for (int i = 0; i < k; i++)
            begin
                dx = longint'(x) - longint'(centroid[i][0]);
                dy = longint'(y) - longint'(centroid[i][1]);
                dz = longint'(z) - longint'(centroid[i][2]);
                d = dx * dx + dy * dy + dz * dz;
                if (i == 0 || d < best_d)
                begin
                    best_d = d;
                    best = i;
                end
            end
            sum_x[best] = sum_x[best] + {{12{x[15]}}, x};
            sum_y[best] = sum_y[best] + {{12{y[15]}}, y};
            sum_z[best] = sum_z[best] + {{12{z[15]}}, z};
            members[best] = members[best] + 13'd1;
            if (prior[slot] != {1'b1, 4'(best)})
                moved = 1'b1;
            prior[slot] = {1'b1, 4'(best)};
            r = '{cid: 4'(best), sqd: 34'(best_d), mx: 0, my: 0, mz: 0, conv: 0, last: 0};
            expected_q = {expected_q, r};
        end
        else if (op == OP_UPDATE)
        begin
            for (int i = 0; i < CLUSTERS; i++)
            begin
                if (i < k)
                begin
                    if (members[i] != 0)
                    begin
                        centroid[i][0] = mean_of(sum_x[i], members[i]);
                        centroid[i][1] = mean_of(sum_y[i], members[i]);
                        centroid[i][2] = mean_of(sum_z[i], members[i]);
                    end
                    r = '{cid: 4'(i), sqd: 0, mx: centroid[i][0], my: centroid[i][1],
                          mz: centroid[i][2], conv: !moved, last: (i == k - 1)};
                    expected_q = {expected_q, r};
                end
                sum_x[i] = 0;
                sum_y[i] = 0;
                sum_z[i] = 0;
                members[i] = 0;
            end
            moved = 1'b0;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic [1:0] op, logic [11:0] slot, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'd0, z, y, x, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_kmeans(op, slot, x, y, z);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        // loads leave no result, so give the unit time to settle
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cluster_count(logic [4:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_CLUSTER_COUNT;
        pwdata  = {24'd0, 3'($urandom_range(7)), value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        k_reg = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        centroid_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[3:0] !== e.cid)
                begin
                    $error("cluster_id exp %0d got %0d", e.cid, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[37:4] !== e.sqd)
                begin
                    $error("squared_distance exp %0d got %0d", e.sqd, m_tdata[37:4]);
                    errors++;
                end
                if (m_tdata[53:38] !== e.mx)
                begin
                    $error("mean_x exp %0d got %0d", e.mx, $signed(m_tdata[53:38]));
                    errors++;
                end
                if (m_tdata[69:54] !== e.my)
                begin
                    $error("mean_y exp %0d got %0d", e.my, $signed(m_tdata[69:54]));
                    errors++;
                end
                if (m_tdata[85:70] !== e.mz)
                begin
                    $error("mean_z exp %0d got %0d", e.mz, $signed(m_tdata[85:70]));
                    errors++;
                end
                if (m_tdata[86] !== e.conv)
                begin
                    $error("converged exp %0d got %0d", e.conv, m_tdata[86]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(OP_UNKNOWN, 12'hFFF, 16'sh7FFF, -16'sd1, 16'sh5A5A);
        send_item(OP_LOAD, 12'd20, 16'sd100, 16'sd100, 16'sd100);   // slot past the store
        send_item(OP_CLASSIFY, 12'd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_LOAD, 12'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_CLASSIFY, 12'd4095, -16'sd32768, -16'sd32768, -16'sd32768);  // max distance
        send_item(OP_UPDATE, 12'd0, 16'sd0, 16'sd0, 16'sd0);
        drain_results();
        write_cluster_count(5'd16);
        send_item(OP_LOAD, 12'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_LOAD, 12'd1, -16'sd32768, -16'sd32768, -16'sd32768);
        send_item(OP_LOAD, 12'd2, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);  // ties with cluster 0
        send_item(OP_LOAD, 12'd15, 16'sd5, -16'sd5, 16'sd0);
        for (int pass = 0; pass < 2; pass++)
        begin
            send_item(OP_CLASSIFY, 12'd4095, -16'sd32768, -16'sd32768, -16'sd32768);
            send_item(OP_CLASSIFY, 12'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
            send_item(OP_CLASSIFY, 12'd0, 16'sd7, -16'sd3, 16'sd1);
            send_item(OP_CLASSIFY, 12'd2, 16'sd6, -16'sd7, 16'sd0);
            send_item(OP_UPDATE, 12'hABC, 16'sd0, 16'sd0, 16'sd0);   // empty clusters kept
        end
        drain_results();
    endtask

    // several k-means runs with fixed point sets so that passes converge
    task automatic test_lloyd_runs();
        logic [4:0]         k_vals[8] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd3, 5'd8, 5'd12, 5'd5};
        logic [11:0]        pt_slot[16];
        logic signed [15:0] pt[16][3];
        int run;
        int n;
        int k;
        int c;
        run = 0;
        while (items_sent < 290)
        begin
            case (run % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
                default: begin src_idle_pct = 37; snk_stall_pct = 37; end
            endcase
            write_cluster_count(run < 8 ? k_vals[run] : 5'($urandom_range(31)));
            k = (k_reg == 0) ? 1 : ((k_reg > CLUSTERS) ? CLUSTERS : int'(k_reg));
            for (int i = 0; i < k + 2; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(OP_UNKNOWN, 12'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                send_item(OP_LOAD, ($urandom_range(7) == 0) ? 12'($urandom) :
                          12'($urandom_range(15)), 16'($urandom), 16'($urandom),
                          16'($urandom));
            end
            n = $urandom_range(4, 14);
            for (int p = 0; p < n; p++)
            begin
                pt_slot[p] = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(31));
                c = $urandom_range(k - 1);
                for (int a = 0; a < 3; a++)
                    pt[p][a] = ($urandom_range(1) == 0) ? 16'($urandom) :
                               16'(centroid[c][a] + $signed(16'($urandom_range(2000))) - 1000);
            end
            for (int it = 0; it < 3; it++)
            begin
                for (int p = 0; p < n; p++)
                    send_item(OP_CLASSIFY, pt_slot[p], pt[p][0], pt[p][1], pt[p][2]);
                send_item(OP_UPDATE, 12'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            end
            drain_results();
            run++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        items_sent = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        k_reg = 5'd1;
        moved = 1'b0;
        for (int i = 0; i < CLUSTERS; i++)
        begin
            centroid[i] = '{0, 0, 0};
            sum_x[i] = 0;
            sum_y[i] = 0;
            sum_z[i] = 0;
            members[i] = 0;
        end
        for (int i = 0; i < MAX_PTS; i++)
            prior[i] = 5'd0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_lloyd_runs();
        drain_results();
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* kmeans_nearest_centroid_update_unit.f */
rtl/kncu_pkg.sv
rtl/kmeans_nearest_centroid_update_unit.sv
bench/tb_top.sv
